### rtl/bfsa_pkg.sv
// ----------------------------------------------------------------------------
// bfsa_pkg
// Shared types and constants for the best-fit split allocator.
// ----------------------------------------------------------------------------
package bfsa_pkg;

    localparam int MAX_BLOCKS_DEF  = 64;
    localparam int ALIGN_BYTES_DEF = 256;
    localparam int ADDR_BITS_DEF   = 48;

    localparam logic [47:0] POOL_BASE_RST      = 48'd4096;
    localparam logic [31:0] POOL_SIZE_RST      = 32'd0;
    localparam logic [15:0] SPLIT_OVERHEAD_RST = 16'd256;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_POOL_BASE      = 2'd0;
    localparam logic [1:0] REG_POOL_SIZE      = 2'd1;
    localparam logic [1:0] REG_SPLIT_OVERHEAD = 2'd2;

    // Request modes.
    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE  = 2'd1;
    localparam logic [1:0] MODE_RESET = 2'd2;
    localparam logic [1:0] MODE_QUERY = 2'd3;

    // Result status codes.
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NULL    = 2'd1;
    localparam logic [1:0] STATUS_OOM     = 2'd2;
    localparam logic [1:0] STATUS_BAD_PTR = 2'd3;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_ROUND,
        ST_SCAN,
        ST_SPLIT_WR,
        ST_GRANT_WR,
        ST_FREE_WR,
        ST_CLEAR,
        ST_DONE
    } state_t;

    // Write controls into the block table.
    typedef struct packed {
        logic        data_we;
        logic        meta_we;
        logic        meta_free;
        logic [15:0] meta_stamp;
    } tbl_wr_t;

endpackage

### rtl/bfsa_table.sv
// ----------------------------------------------------------------------------
// bfsa_table
// Block table: base/size memory and free/stamp memory, registered read.
// ----------------------------------------------------------------------------
module bfsa_table #(
    parameter int MAX_BLOCKS = bfsa_pkg::MAX_BLOCKS_DEF,
    parameter int ADDR_BITS  = bfsa_pkg::ADDR_BITS_DEF,
    localparam int IW = $clog2(MAX_BLOCKS)
) (
    input  logic                 clk,
    input  logic [IW-1:0]        rd_addr,
    output logic [ADDR_BITS-1:0] rd_base,
    output logic [31:0]          rd_bytes,
    output logic                 rd_free,
    output logic [15:0]          rd_stamp,
    input  bfsa_pkg::tbl_wr_t    wr,
    input  logic [IW-1:0]        wr_addr,
    input  logic [ADDR_BITS-1:0] wr_base,
    input  logic [31:0]          wr_bytes
);

    logic [ADDR_BITS+31:0] data_mem [MAX_BLOCKS];
    logic [16:0]           meta_mem [MAX_BLOCKS];

    always_ff @(posedge clk)
    begin
        if (wr.data_we)
        begin
            data_mem[wr_addr] <= {wr_base, wr_bytes};
        end
        if (wr.meta_we)
        begin
            meta_mem[wr_addr] <= {wr.meta_free, wr.meta_stamp};
        end
        {rd_base, rd_bytes} <= data_mem[rd_addr];
        {rd_free, rd_stamp} <= meta_mem[rd_addr];
    end

endmodule

### rtl/bfsa_round.sv
// ----------------------------------------------------------------------------
// bfsa_round
// Rounds a request size up to the alignment through multiply, subtract and fix steps.
// ----------------------------------------------------------------------------
module bfsa_round #(
    parameter int ALIGN_BYTES = bfsa_pkg::ALIGN_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] req,
    output logic        done,
    output logic [32:0] aligned
);

    // The quotient comes from a multiply by the scaled reciprocal of the
    // alignment. That estimate is at most one short, so a single compare
    // and subtract brings the remainder below the alignment.
    localparam logic [32:0] RECIP   = 33'((64'd1 << 32) / 64'(ALIGN_BYTES));
    localparam logic [31:0] ALIGN_W = 32'(ALIGN_BYTES);

    logic        mul_reg, mul_next;
    logic        sub_reg, sub_next;
    logic        fix_reg, fix_next;
    logic        done_reg, done_next;
    logic [31:0] req_reg, req_next;
    logic [31:0] quot_reg, quot_next;
    logic [31:0] rem_reg, rem_next;
    logic [64:0] prod;

    always_comb
    begin
        mul_next  = start;
        sub_next  = mul_reg;
        fix_next  = sub_reg;
        done_next = fix_reg;
        req_next  = start ? req : req_reg;
        prod      = 65'(req_reg) * 65'(RECIP);
        quot_next = mul_reg ? prod[63:32] : quot_reg;
        rem_next  = rem_reg;
        if (sub_reg)
        begin
            rem_next = req_reg - quot_reg * ALIGN_W;
        end
        else if (fix_reg && (rem_reg >= ALIGN_W))
        begin
            rem_next = rem_reg - ALIGN_W;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_reg  <= 1'b0;
            sub_reg  <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            mul_reg  <= mul_next;
            sub_reg  <= sub_next;
            fix_reg  <= fix_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign done    = done_reg;
    assign aligned = {1'b0, req_reg}
                   + ((rem_reg == 32'd0) ? 33'd0 : {1'b0, ALIGN_W - rem_reg});

endmodule

### rtl/best_fit_split_allocator_unit.sv
// ----------------------------------------------------------------------------
// best_fit_split_allocator_unit
// Best-fit block allocator with splitting over one address pool.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                Direction  Purpose
//  in        in_valid/in_ready, mode, request_size,  in         one request item
//            address
//  out       out_valid/out_ready, granted_address,   out        one result item
//            status, block_bytes, in_pool,
//            bytes_in_use
//  cfg       psel/penable/pwrite/paddr/pwdata/       in/out     APB registers
//            prdata/pready
//
// Steps, from acceptance to the result register: an allocate first rounds
// the size in the rounding unit, then scans the live entries through the
// table memory, then takes one or two write states (split, grant) and posts
// the result from the done state. Query and free scan the same way; a good
// free adds a free write. Reset mode sweeps the live entries; a null request
// goes straight to the done state.
// The unit then returns to idle before it takes the next item.
// The single read port of the table sets the scan length.
// After rst_n and after any write of pool_base or pool_size the unit rewrites
// table entry zero in its init state before it accepts an item.
// One item is in work at a time; a finished result sits in the output
// register so that the next item can be taken while it waits for out_ready.
// ----------------------------------------------------------------------------
module best_fit_split_allocator_unit #(
    parameter int MAX_BLOCKS  = bfsa_pkg::MAX_BLOCKS_DEF,
    parameter int ALIGN_BYTES = bfsa_pkg::ALIGN_BYTES_DEF,
    parameter int ADDR_BITS   = bfsa_pkg::ADDR_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [31:0] request_size,
    input  logic [47:0] address,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [47:0] granted_address,
    output logic [1:0]  status,
    output logic [31:0] block_bytes,
    output logic        in_pool,
    output logic [31:0] bytes_in_use,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int IW   = $clog2(MAX_BLOCKS);
    localparam int CNTW = $clog2(MAX_BLOCKS + 1);
    localparam int CW   = (ADDR_BITS > 48) ? ADDR_BITS : 48;
    localparam logic [CNTW-1:0] MAX_CNT = CNTW'(MAX_BLOCKS);

    // Configuration registers.
    logic [47:0] pool_base_reg;
    logic [31:0] pool_size_reg;
    logic [15:0] split_overhead_reg;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;
    logic        rebuild;

    // Allocator state outside the table.
    logic [CNTW-1:0] count_reg, count_next;
    logic [15:0]     stamp_ctr_reg, stamp_ctr_next;
    logic [31:0]     used_reg, used_next;

    bfsa_pkg::state_t state_reg, state_next;

    // Request held while in work.
    logic [1:0]  mode_reg, mode_next;
    logic [47:0] addr_reg, addr_next;
    logic [32:0] aligned_reg, aligned_next;

    // Scan bookkeeping; issue_idx doubles as the sweep index in reset mode.
    logic [CNTW-1:0]      issue_idx_reg, issue_idx_next;
    logic                 pend_reg, pend_next;
    logic [IW-1:0]        pend_idx_reg, pend_idx_next;
    logic                 found_reg, found_next;
    logic [IW-1:0]        best_idx_reg, best_idx_next;
    logic [31:0]          best_bytes_reg, best_bytes_next;
    logic [15:0]          best_stamp_reg, best_stamp_next;
    logic [ADDR_BITS-1:0] best_base_reg, best_base_next;
    logic [31:0]          rem_reg, rem_next;

    // Result being built, and the output register.
    logic [47:0] res_granted_reg, res_granted_next;
    logic [1:0]  res_status_reg, res_status_next;
    logic [31:0] res_bytes_reg, res_bytes_next;
    logic        res_inpool_reg, res_inpool_next;
    logic        out_valid_reg, out_valid_next;
    logic [47:0] out_granted_reg, out_granted_next;
    logic [1:0]  out_status_reg, out_status_next;
    logic [31:0] out_bytes_reg, out_bytes_next;
    logic        out_inpool_reg, out_inpool_next;
    logic [31:0] out_used_reg, out_used_next;

    // Table and rounding unit hookup.
    logic [IW-1:0]        rd_addr;
    logic [ADDR_BITS-1:0] rd_base;
    logic [31:0]          rd_bytes;
    logic                 rd_free;
    logic [15:0]          rd_stamp;
    bfsa_pkg::tbl_wr_t    tbl_wr;
    logic [IW-1:0]        wr_addr;
    logic [ADDR_BITS-1:0] wr_base;
    logic [31:0]          wr_bytes;
    logic                 rnd_start;
    logic                 rnd_done;
    logic [32:0]          rnd_aligned;

    logic        in_acc;
    logic        issuing;
    logic        cand_fit;
    logic        cand_better;
    logic        cand_match;
    logic [48:0] pool_end;

    // ------------------------------------------------------------------
    // Configuration port. Writing the pool registers rebuilds the table.
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:3];
    assign cfg_wr  = psel && penable && pwrite;
    assign rebuild = cfg_wr && (cfg_idx inside {bfsa_pkg::REG_POOL_BASE,
                                                bfsa_pkg::REG_POOL_SIZE});

    always_comb
    begin
        case (cfg_idx)
            bfsa_pkg::REG_POOL_BASE:      prdata = {16'd0, pool_base_reg};
            bfsa_pkg::REG_POOL_SIZE:      prdata = {32'd0, pool_size_reg};
            bfsa_pkg::REG_SPLIT_OVERHEAD: prdata = {48'd0, split_overhead_reg};
            default:                      prdata = 64'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg      <= bfsa_pkg::POOL_BASE_RST;
            pool_size_reg      <= bfsa_pkg::POOL_SIZE_RST;
            split_overhead_reg <= bfsa_pkg::SPLIT_OVERHEAD_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                bfsa_pkg::REG_POOL_BASE:      pool_base_reg      <= pwdata[47:0];
                bfsa_pkg::REG_POOL_SIZE:      pool_size_reg      <= pwdata[31:0];
                bfsa_pkg::REG_SPLIT_OVERHEAD: split_overhead_reg <= pwdata[15:0];
                default:                      ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Scan datapath. A read issued in one cycle is judged the next.
    // ------------------------------------------------------------------
    assign in_ready = (state_reg == bfsa_pkg::ST_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign issuing  = (state_reg == bfsa_pkg::ST_SCAN) && (issue_idx_reg < count_reg);
    assign pool_end = {1'b0, pool_base_reg} + {17'd0, pool_size_reg};

    // Allocate: smallest fitting free block, ties to the lower stamp; the
    // scan runs in index order so a full tie keeps the lower index.
    assign cand_fit    = rd_free && (rd_bytes >= aligned_reg[31:0]);
    assign cand_better = !found_reg || (rd_bytes < best_bytes_reg)
                       || (rd_bytes == best_bytes_reg && rd_stamp < best_stamp_reg);
    // Free and query: the first allocated block whose base is the address.
    assign cand_match  = !rd_free && (CW'(rd_base) == CW'(addr_reg)) && !found_reg;

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        stamp_ctr_next   = stamp_ctr_reg;
        used_next        = used_reg;
        mode_next        = mode_reg;
        addr_next        = addr_reg;
        aligned_next     = aligned_reg;
        issue_idx_next   = issue_idx_reg;
        pend_next        = 1'b0;
        pend_idx_next    = issue_idx_reg[IW-1:0];
        found_next       = found_reg;
        best_idx_next    = best_idx_reg;
        best_bytes_next  = best_bytes_reg;
        best_stamp_next  = best_stamp_reg;
        best_base_next   = best_base_reg;
        rem_next         = rem_reg;
        res_granted_next = res_granted_reg;
        res_status_next  = res_status_reg;
        res_bytes_next   = res_bytes_reg;
        res_inpool_next  = res_inpool_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_granted_next = out_granted_reg;
        out_status_next  = out_status_reg;
        out_bytes_next   = out_bytes_reg;
        out_inpool_next  = out_inpool_reg;
        out_used_next    = out_used_reg;
        rd_addr          = issue_idx_reg[IW-1:0];
        tbl_wr           = '0;
        wr_addr          = best_idx_reg;
        wr_base          = best_base_reg;
        wr_bytes         = best_bytes_reg;
        rnd_start        = 1'b0;

        case (state_reg)
            bfsa_pkg::ST_INIT:
            begin
                tbl_wr.data_we  = 1'b1;
                tbl_wr.meta_we  = 1'b1;
                tbl_wr.meta_free = 1'b1;
                wr_addr         = '0;
                wr_base         = ADDR_BITS'(pool_base_reg);
                wr_bytes        = pool_size_reg;
                state_next      = bfsa_pkg::ST_IDLE;
            end

            bfsa_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    mode_next        = mode;
                    addr_next        = address;
                    issue_idx_next   = '0;
                    found_next       = 1'b0;
                    res_granted_next = 48'd0;
                    res_status_next  = bfsa_pkg::STATUS_OK;
                    res_bytes_next   = 32'd0;
                    res_inpool_next  = 1'b0;
                    case (mode)
                        bfsa_pkg::MODE_ALLOC:
                        begin
                            if (request_size == 32'd0)
                            begin
                                res_status_next = bfsa_pkg::STATUS_NULL;
                                state_next      = bfsa_pkg::ST_DONE;
                            end
                            else
                            begin
                                rnd_start  = 1'b1;
                                state_next = bfsa_pkg::ST_ROUND;
                            end
                        end
                        bfsa_pkg::MODE_RESET:
                        begin
                            state_next = bfsa_pkg::ST_CLEAR;
                        end
                        default:
                        begin
                            if (address == 48'd0)
                            begin
                                res_status_next = bfsa_pkg::STATUS_NULL;
                                state_next      = bfsa_pkg::ST_DONE;
                            end
                            else
                            begin
                                state_next = bfsa_pkg::ST_SCAN;
                            end
                        end
                    endcase
                end
            end

            bfsa_pkg::ST_ROUND:
            begin
                if (rnd_done)
                begin
                    aligned_next = rnd_aligned;
                    if (rnd_aligned[32])
                    begin
                        res_status_next = bfsa_pkg::STATUS_OOM;
                        state_next      = bfsa_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = bfsa_pkg::ST_SCAN;
                    end
                end
            end

            bfsa_pkg::ST_SCAN:
            begin
                if (issuing)
                begin
                    pend_next      = 1'b1;
                    issue_idx_next = issue_idx_reg + CNTW'(1);
                end
                if (pend_reg)
                begin
                    if ((mode_reg == bfsa_pkg::MODE_ALLOC) ? (cand_fit && cand_better)
                                                          : cand_match)
                    begin
                        found_next      = 1'b1;
                        best_idx_next   = pend_idx_reg;
                        best_bytes_next = rd_bytes;
                        best_stamp_next = rd_stamp;
                        best_base_next  = rd_base;
                    end
                end
                else if (!issuing)
                begin
                    case (mode_reg)
                        bfsa_pkg::MODE_ALLOC:
                        begin
                            rem_next = best_bytes_reg - aligned_reg[31:0];
                            if (!found_reg)
                            begin
                                res_status_next = bfsa_pkg::STATUS_OOM;
                                state_next      = bfsa_pkg::ST_DONE;
                            end
                            else if (rem_next > 32'(split_overhead_reg)
                                     && count_reg < MAX_CNT)
                            begin
                                state_next = bfsa_pkg::ST_SPLIT_WR;
                            end
                            else
                            begin
                                state_next = bfsa_pkg::ST_GRANT_WR;
                            end
                        end
                        bfsa_pkg::MODE_FREE:
                        begin
                            if (!found_reg)
                            begin
                                res_status_next = bfsa_pkg::STATUS_BAD_PTR;
                                state_next      = bfsa_pkg::ST_DONE;
                            end
                            else
                            begin
                                state_next = bfsa_pkg::ST_FREE_WR;
                            end
                        end
                        default:
                        begin
                            res_bytes_next  = found_reg ? best_bytes_reg : 32'd0;
                            res_inpool_next = (pool_size_reg != 32'd0)
                                            && (addr_reg >= pool_base_reg)
                                            && ({1'b0, addr_reg} < pool_end);
                            state_next      = bfsa_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            bfsa_pkg::ST_SPLIT_WR:
            begin
                // The remainder goes to a new free entry at the table end.
                tbl_wr.data_we   = 1'b1;
                tbl_wr.meta_we   = 1'b1;
                tbl_wr.meta_free = 1'b1;
                tbl_wr.meta_stamp = stamp_ctr_reg;
                wr_addr          = count_reg[IW-1:0];
                wr_base          = best_base_reg + ADDR_BITS'(aligned_reg[31:0]);
                wr_bytes         = rem_reg;
                stamp_ctr_next   = stamp_ctr_reg + 16'd1;
                count_next       = count_reg + CNTW'(1);
                best_bytes_next  = aligned_reg[31:0];
                state_next       = bfsa_pkg::ST_GRANT_WR;
            end

            bfsa_pkg::ST_GRANT_WR:
            begin
                tbl_wr.data_we    = 1'b1;
                tbl_wr.meta_we    = 1'b1;
                tbl_wr.meta_stamp = best_stamp_reg;
                used_next         = used_reg + best_bytes_reg;
                res_granted_next  = 48'(best_base_reg);
                res_bytes_next    = best_bytes_reg;
                state_next        = bfsa_pkg::ST_DONE;
            end

            bfsa_pkg::ST_FREE_WR:
            begin
                tbl_wr.meta_we    = 1'b1;
                tbl_wr.meta_free  = 1'b1;
                tbl_wr.meta_stamp = stamp_ctr_reg;
                stamp_ctr_next    = stamp_ctr_reg + 16'd1;
                used_next         = used_reg - best_bytes_reg;
                state_next        = bfsa_pkg::ST_DONE;
            end

            bfsa_pkg::ST_CLEAR:
            begin
                // Only live entries need clearing; the rest are rewritten
                // by a split before any scan reaches them.
                if (issue_idx_reg < count_reg)
                begin
                    tbl_wr.meta_we    = 1'b1;
                    tbl_wr.meta_free  = 1'b1;
                    tbl_wr.meta_stamp = 16'(issue_idx_reg);
                    wr_addr           = issue_idx_reg[IW-1:0];
                    issue_idx_next    = issue_idx_reg + CNTW'(1);
                end
                else
                begin
                    stamp_ctr_next = 16'(count_reg);
                    used_next      = 32'd0;
                    state_next     = bfsa_pkg::ST_DONE;
                end
            end

            bfsa_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    out_granted_next = res_granted_reg;
                    out_status_next  = res_status_reg;
                    out_bytes_next   = res_bytes_reg;
                    out_inpool_next  = res_inpool_reg;
                    out_used_next    = used_reg;
                    state_next       = bfsa_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = bfsa_pkg::ST_INIT;
            end
        endcase

        // A pool register write starts a fresh table of one free block, or an empty one when the pool size is zero.
        if (rebuild)
        begin
            state_next     = bfsa_pkg::ST_INIT;
            count_next     = CNTW'(1);
            stamp_ctr_next = 16'd1;
            used_next      = 32'd0;
            if (cfg_idx == bfsa_pkg::REG_POOL_SIZE)
            begin
                count_next = (pwdata[31:0] != 32'd0) ? CNTW'(1) : '0;
            end
            else
            begin
                count_next = (pool_size_reg != 32'd0) ? CNTW'(1) : '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bfsa_pkg::ST_INIT;
            count_reg     <= (bfsa_pkg::POOL_SIZE_RST != 32'd0) ? CNTW'(1) : '0;
            stamp_ctr_reg <= 16'd1;
            used_reg      <= 32'd0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            stamp_ctr_reg <= stamp_ctr_next;
            used_reg      <= used_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg        <= mode_next;
        addr_reg        <= addr_next;
        aligned_reg     <= aligned_next;
        issue_idx_reg   <= issue_idx_next;
        pend_idx_reg    <= pend_idx_next;
        found_reg       <= found_next;
        best_idx_reg    <= best_idx_next;
        best_bytes_reg  <= best_bytes_next;
        best_stamp_reg  <= best_stamp_next;
        best_base_reg   <= best_base_next;
        rem_reg         <= rem_next;
        res_granted_reg <= res_granted_next;
        res_status_reg  <= res_status_next;
        res_bytes_reg   <= res_bytes_next;
        res_inpool_reg  <= res_inpool_next;
        out_granted_reg <= out_granted_next;
        out_status_reg  <= out_status_next;
        out_bytes_reg   <= out_bytes_next;
        out_inpool_reg  <= out_inpool_next;
        out_used_reg    <= out_used_next;
    end

    assign out_valid       = out_valid_reg;
    assign granted_address = out_granted_reg;
    assign status          = out_status_reg;
    assign block_bytes     = out_bytes_reg;
    assign in_pool         = out_inpool_reg;
    assign bytes_in_use    = out_used_reg;

    bfsa_table #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_table (
        .clk      (clk),
        .rd_addr  (rd_addr),
        .rd_base  (rd_base),
        .rd_bytes (rd_bytes),
        .rd_free  (rd_free),
        .rd_stamp (rd_stamp),
        .wr       (tbl_wr),
        .wr_addr  (wr_addr),
        .wr_base  (wr_base),
        .wr_bytes (wr_bytes)
    );

    bfsa_round #(
        .ALIGN_BYTES (ALIGN_BYTES)
    ) u_round (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (rnd_start),
        .req     (request_size),
        .done    (rnd_done),
        .aligned (rnd_aligned)
    );

    // The table never holds more entries than it has rows.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("entry count beyond table depth");

    // A split write is always followed by the grant write.
    a_split_grant: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bfsa_pkg::ST_SPLIT_WR |=> state_reg == bfsa_pkg::ST_GRANT_WR)
        else $error("split not followed by grant");

    // No table read is in flight once the unit is back to idle.
    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bfsa_pkg::ST_IDLE |-> !pend_reg)
        else $error("scan read pending in idle");

    // A granted block always has a nonzero size.
    a_grant_size: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_granted_reg != 48'd0 |-> out_bytes_reg != 32'd0)
        else $error("granted block with zero size");

endmodule
